/* sv/rtdc_pkg.sv */
package rtdc_pkg;

  localparam int unsigned MV_W    = 12;
  localparam int unsigned OHM_W   = 16;
  localparam int unsigned DEG_W   = 8;
  localparam int unsigned NUM_W   = MV_W + OHM_W;   // series * mv
  localparam int unsigned LANES   = 2;

  // Serial divider: one quotient bit per cycle over the full numerator width.
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // PT1000 linear conversion: degrees = (ohm - 1000) * 100 / 385.
  localparam logic [NUM_W-1:0] OHM_BASE   = NUM_W'(1000);
  localparam logic [6:0]       DEG_SCALE  = 7'd100;
  // Below 997 ohm the truncated temperature is negative; above 1985 ohm it
  // exceeds 255 degrees and so any 8-bit limit.
  localparam logic [NUM_W-1:0] OHM_MIN_OK = NUM_W'(997);
  localparam logic [NUM_W-1:0] OHM_MAX_OK = NUM_W'(1985);
  localparam int unsigned      X_W        = 10;
  localparam int unsigned      SCALED_W   = 17;

  // Divide by the 385 slope through a reciprocal: ceil(2^26 / 385). The
  // rounding error stays below one quotient step for numerators up to 98500.
  localparam int unsigned        RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] SLOPE_RECIP = RECIP_W'(174309);
  localparam int unsigned        SLOPE_SHIFT = 26;
  localparam int unsigned        PROD_W      = SCALED_W + RECIP_W;

  // Register map
  localparam logic [1:0] REG_WARM   = 2'd0;
  localparam logic [1:0] REG_LIMIT  = 2'd1;
  localparam logic [1:0] REG_SUPPLY = 2'd2;
  localparam logic [1:0] REG_SERIES = 2'd3;

  localparam logic [7:0]       WARM_RST   = 8'd50;
  localparam logic [7:0]       LIMIT_RST  = 8'd200;
  localparam logic [MV_W-1:0]  SUPPLY_RST = MV_W'(3280);
  localparam logic [OHM_W-1:0] SERIES_RST = OHM_W'(1200);

  localparam logic [1:0] ST_COLD    = 2'd0;
  localparam logic [1:0] ST_WARM    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_TO_WARM = 2'd1;
  localparam logic [1:0] EV_TO_COLD = 2'd2;

  typedef struct packed {
    logic [MV_W-1:0] first_probe_mv;
    logic [MV_W-1:0] second_probe_mv;
  } in_data_t;

  typedef struct packed {
    logic [1:0]       first_status;
    logic [1:0]       first_event;
    logic             first_led_toggle;
    logic [DEG_W-1:0] first_degrees;
    logic [1:0]       second_status;
    logic [1:0]       second_event;
    logic             second_led_toggle;
    logic [DEG_W-1:0] second_degrees;
  } out_data_t;

  typedef struct packed {
    logic load;   // start resistance division from a new sample
    logic step;   // one restoring division step
    logic mid;    // turn resistance into scaled numerator for the slope division
    logic scale;  // divide the scaled numerator by the slope
  } lane_ctl_t;

  typedef struct packed {
    logic             bad;
    logic [DEG_W-1:0] deg;
  } lane_res_t;

endpackage

/* sv/rtdc_lane.sv */
module rtdc_lane (
  input  logic                          clk,
  input  rtdc_pkg::lane_ctl_t           ctl,
  input  logic [rtdc_pkg::MV_W-1:0]     mv,
  input  logic [rtdc_pkg::MV_W-1:0]     supply,
  input  logic [rtdc_pkg::OHM_W-1:0]    series,
  input  logic [rtdc_pkg::DEG_W-1:0]    limit,
  output rtdc_pkg::lane_res_t           res
);
  import rtdc_pkg::*;

  logic [NUM_W-1:0]    quo_r, quo_nxt;
  logic [MV_W-1:0]     rem_r, rem_nxt;
  logic [MV_W-1:0]     den_r, den_nxt;
  logic                bad_r, bad_nxt;
  logic [MV_W:0]       trial;
  logic [MV_W:0]       trial_diff;
  logic                fits;
  logic [NUM_W-1:0]    ohm_off;
  logic [X_W-1:0]      x;
  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]   prod;

  always_comb begin
    trial      = {rem_r, quo_r[NUM_W-1]};
    trial_diff = trial - {1'b0, den_r};
    fits       = (trial >= {1'b0, den_r});
    ohm_off    = quo_r - OHM_BASE;
    // Resistance in 997..999 truncates to zero degrees.
    x          = (quo_r < OHM_BASE) ? '0 : ohm_off[X_W-1:0];
    scaled     = SCALED_W'(x) * SCALED_W'(DEG_SCALE);
    prod       = PROD_W'(quo_r[SCALED_W-1:0]) * PROD_W'(SLOPE_RECIP);

    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    bad_nxt = bad_r;
    if (ctl.load) begin
      bad_nxt = (mv >= supply);
      den_nxt = supply - mv;
      quo_nxt = NUM_W'(series) * NUM_W'(mv);
      rem_nxt = '0;
    end else if (ctl.step) begin
      rem_nxt = fits ? trial_diff[MV_W-1:0] : trial[MV_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
    end else if (ctl.mid) begin
      bad_nxt = bad_r | (quo_r < OHM_MIN_OK) | (quo_r > OHM_MAX_OK);
      quo_nxt = NUM_W'(scaled);
    end else if (ctl.scale) begin
      quo_nxt = NUM_W'(prod[SLOPE_SHIFT +: DEG_W]);
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    bad_r <= bad_nxt;
  end

  assign res.deg = quo_r[DEG_W-1:0];
  assign res.bad = bad_r | (quo_r[DEG_W-1:0] > limit);

endmodule

/* sv/rtdc_merge.sv */
module rtdc_merge (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     commit,
  input  rtdc_pkg::lane_res_t [rtdc_pkg::LANES-1:0] res,
  input  logic [rtdc_pkg::DEG_W-1:0]               warm,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output rtdc_pkg::out_data_t                      out_data
);
  import rtdc_pkg::*;

  logic [LANES-1:0][1:0]       last_r, last_nxt;
  logic [LANES-1:0][1:0]       status;
  logic [LANES-1:0][1:0]       event_code;
  logic [LANES-1:0][DEG_W-1:0] degrees;
  logic                        out_valid_r, out_valid_nxt;
  out_data_t                   out_data_r, out_data_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      event_code[i] = EV_NONE;
      degrees[i]    = '0;
      if (res[i].bad) begin
        status[i] = ST_INVALID;
      end else if (res[i].deg > warm) begin
        status[i]  = ST_WARM;
        degrees[i] = res[i].deg;
        if (last_r[i] != ST_WARM) event_code[i] = EV_TO_WARM;
      end else begin
        status[i]  = ST_COLD;
        degrees[i] = res[i].deg;
        if (last_r[i] != ST_COLD) event_code[i] = EV_TO_COLD;
      end
    end

    last_nxt      = commit ? status : last_r;
    out_valid_nxt = commit | (out_valid_r & ~out_ready);

    out_data_nxt = out_data_r;
    if (commit) begin
      out_data_nxt.first_status      = status[0];
      out_data_nxt.first_event       = event_code[0];
      out_data_nxt.first_led_toggle  = res[0].bad;
      out_data_nxt.first_degrees     = degrees[0];
      out_data_nxt.second_status     = status[1];
      out_data_nxt.second_event      = event_code[1];
      out_data_nxt.second_led_toggle = res[1].bad;
      out_data_nxt.second_degrees    = degrees[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= {LANES{ST_INVALID}};
      out_valid_r <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/rtd_probe_temperature_classifier.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------
// input    | in_valid / in_ready  | in_data (two probe samples, mV)
// result   | out_valid/out_ready  | out_data (status, event, LED, degrees x2)
// config   | psel/penable/pready  | paddr, pwdata, prdata (4 registers)
//
// From its beat an item runs 28 restoring-division steps for the resistance,
// a rescale step, one reciprocal multiply for the 385-ohm slope, a handover
// into the output register, and then its result is offered. The next beat
// can be taken in the cycle the result is first offered, when the sequencer
// is back in idle; no new item is taken before the last is handed over.
// Each probe has its own divider lane.
// Synchronous active-low reset clears the sequencer, the kept statuses
// (to invalid), the result valid and the registers to their defaults.
// A stalled result holds in the output register; a finished item waits in
// the last state until that register frees up.
module rtd_probe_temperature_classifier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtdc_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rtdc_pkg::out_data_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rtdc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV1  = 5'b00010,
    S_MID   = 5'b00100,
    S_SCALE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  lane_ctl_t          ctl;
  logic               commit;
  logic               last_step;
  logic [1:0]         reg_idx;
  logic               cfg_wr;

  logic [DEG_W-1:0]   warm_r;
  logic [DEG_W-1:0]   limit_r;
  logic [MV_W-1:0]    supply_r;
  logic [OHM_W-1:0]   series_r;

  logic [LANES-1:0][MV_W-1:0] lane_mv;
  lane_res_t [LANES-1:0]      lane_res;

  // Configuration port: zero-wait, write on the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r   <= WARM_RST;
      limit_r  <= LIMIT_RST;
      supply_r <= SUPPLY_RST;
      series_r <= SERIES_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WARM:   warm_r   <= pwdata[DEG_W-1:0];
        REG_LIMIT:  limit_r  <= pwdata[DEG_W-1:0];
        REG_SUPPLY: supply_r <= pwdata[MV_W-1:0];
        REG_SERIES: series_r <= pwdata[OHM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WARM:   prdata = 32'(warm_r);
      REG_LIMIT:  prdata = 32'(limit_r);
      REG_SUPPLY: prdata = 32'(supply_r);
      REG_SERIES: prdata = 32'(series_r);
      default:    prdata = '0;
    endcase
  end

  // Sequencer shared by both lanes: every lane runs the same step count.
  assign in_ready  = (state_r == S_IDLE);
  assign last_step = (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        ctl.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_step) state_nxt = S_MID;
      end
      S_MID: begin
        ctl.mid   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        // Apply the slope reciprocal in one step.
        ctl.scale = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand over once the output register is empty or draining.
        if (!out_valid || out_ready) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign lane_mv[0] = in_data.first_probe_mv;
  assign lane_mv[1] = in_data.second_probe_mv;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rtdc_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .mv     (lane_mv[g]),
      .supply (supply_r),
      .series (series_r),
      .limit  (limit_r),
      .res    (lane_res[g])
    );
  end

  rtdc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (commit),
    .res       (lane_res),
    .warm      (warm_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* tb/testbench.sv */
module testbench;
  import rtdc_pkg::*;

  // Linear PT1000 conversion constants, kept signed for the predictor math.
  localparam longint PT_NOMINAL_OHM = 1000;
  localparam longint PT_SCALE       = 100;
  localparam longint PT_SLOPE_OHM   = 385;

  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 113;
  localparam int unsigned HOLD_OFF_LEN = 400;
  localparam int unsigned DRAIN_CYCLES = 100;

  // One row of the directed table: two samples and, where obvious, the result.
  typedef struct packed {
    logic [MV_W-1:0] first_mv;
    logic [MV_W-1:0] second_mv;
    logic            typed;
    out_data_t       want;
  } probe_row_t;

  localparam out_data_t BOTH_BAD = '{ST_INVALID, EV_NONE, 1'b1, 8'd0,
                                     ST_INVALID, EV_NONE, 1'b1, 8'd0};
  localparam out_data_t UNTYPED  = '0;

  // Defaults apply here: warm above 50, invalid above 200, 3280 mV, 1200 ohm.
  localparam int unsigned DIR_ROWS = 18;
  localparam probe_row_t DIRECTED [DIR_ROWS] = '{
    '{12'd0,    12'd4095, 1'b1, BOTH_BAD},  // zero sample and full scale
    '{12'd3280, 12'd3279, 1'b1, BOTH_BAD},  // at supply, one below (huge ohm)
    '{12'd1491, 12'd1490, 1'b0, UNTYPED},   // 0 degrees; small negative to 0
    '{12'd1489, 12'd1488, 1'b0, UNTYPED},   // 0 degrees; -1 degree is bad
    '{12'd1638, 12'd1700, 1'b0, UNTYPED},   // around the warm threshold
    '{12'd1700, 12'd1491, 1'b0, UNTYPED},
    '{12'd1800, 12'd1489, 1'b0, UNTYPED},
    '{12'd1950, 12'd1960, 1'b0, UNTYPED},   // around the invalid limit
    '{12'd1955, 12'd1965, 1'b0, UNTYPED},
    '{12'd1970, 12'd1940, 1'b0, UNTYPED},
    '{12'd2000, 12'd2100, 1'b0, UNTYPED},
    '{12'd1600, 12'd1620, 1'b0, UNTYPED},
    '{12'd1640, 12'd1650, 1'b0, UNTYPED},
    '{12'd1,    12'd4094, 1'b0, UNTYPED},
    '{12'd2048, 12'd1024, 1'b0, UNTYPED},
    '{12'd2730, 12'd1365, 1'b0, UNTYPED},   // alternating bit patterns
    '{12'd1500, 12'd1500, 1'b0, UNTYPED},
    '{12'd1500, 12'd1700, 1'b0, UNTYPED}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_data_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_data_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the registers and of each probe's kept status.
  logic [7:0]       warm_thr;
  logic [7:0]       bad_limit;
  logic [MV_W-1:0]  supply_r;
  logic [OHM_W-1:0] series_r;
  logic [1:0]       first_kept;
  logic [1:0]       second_kept;

  out_data_t   expected_readings [$];
  int unsigned mismatch_count = 0;
  int unsigned samples_sent = 0;
  int unsigned hold_off_cycles = 0;
  bit          sender_no_gaps = 1'b0;

  always #6 clk = ~clk;

  rtd_probe_temperature_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Grade one probe sample: divider resistance, linear temperature, then status.
  // The kept status advances to the new status on every sample.
  function automatic void grade_probe(input logic [MV_W-1:0] mv, inout logic [1:0] kept,
                                      output logic [1:0] status, output logic [1:0] change,
                                      output logic led, output logic [7:0] degrees);
    logic   bad;
    longint ohm;
    longint deg;
    bad = 1'b0;
    deg = 0;
    change = EV_NONE;
    if (mv >= supply_r) begin
      bad = 1'b1;  // at or above supply: no division at all
    end else begin
      ohm = (longint'(series_r) * longint'(mv)) / (longint'(supply_r) - longint'(mv));
      deg = ((ohm - PT_NOMINAL_OHM) * PT_SCALE) / PT_SLOPE_OHM;
      if (deg < 0 || deg > longint'(bad_limit)) bad = 1'b1;
    end
    if (bad) begin
      status = ST_INVALID;
      deg = 0;
    end else if (deg > longint'(warm_thr)) begin
      status = ST_WARM;
      if (kept != ST_WARM) change = EV_TO_WARM;
    end else begin
      status = ST_COLD;
      if (kept != ST_COLD) change = EV_TO_COLD;
    end
    kept = status;
    led = bad;
    degrees = deg[7:0];
  endfunction

  function automatic out_data_t classify_reading(input in_data_t s);
    out_data_t r;
    grade_probe(s.first_probe_mv, first_kept, r.first_status, r.first_event,
                r.first_led_toggle, r.first_degrees);
    grade_probe(s.second_probe_mv, second_kept, r.second_status, r.second_event,
                r.second_led_toggle, r.second_degrees);
    return r;
  endfunction

  // Mostly aim at a resistance near the valid band so all statuses show up;
  // the rest lands near the supply or anywhere in the 12-bit range.
  function automatic logic [MV_W-1:0] pick_sample_mv();
    int unsigned roll;
    longint      ohm;
    longint      span;
    longint      mv;
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      ohm  = $urandom_range(950, 2050);
      span = longint'(series_r) + ohm;
      mv   = (ohm * longint'(supply_r) + span / 2) / span + longint'($urandom_range(0, 4)) - 2;
    end else if (roll == 7) begin
      mv = longint'(supply_r) - 1 + longint'($urandom_range(0, 2));
    end else begin
      mv = $urandom_range(0, 4095);
    end
    if (mv < 0) mv = 0;
    if (mv > 4095) mv = 4095;
    return mv[MV_W-1:0];
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Write one register: setup cycle, access cycle, then release the bus.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WARM:   warm_thr  = value[7:0];
      REG_LIMIT:  bad_limit = value[7:0];
      REG_SUPPLY: supply_r  = value[MV_W-1:0];
      REG_SERIES: series_r  = value[OHM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one beat after a random gap and hold it until taken. Call at a
  // rising edge; return at the edge that took the beat.
  task automatic send_sample(input in_data_t s, input logic typed, input out_data_t want);
    int unsigned gap;
    out_data_t   predicted;
    if (samples_sent % 50 == 0) sender_no_gaps = ($urandom_range(0, 3) == 0);
    gap = sender_no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = classify_reading(s);
    expected_readings.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  task automatic wait_for_drain();
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed table at reset defaults, then phases of random beats, the
  // first at the defaults, each later one under its own register setting written while the block is idle.
  initial begin
    in_data_t    s;
    logic [7:0]  warm_cfg;
    logic [7:0]  limit_cfg;
    logic [11:0] supply_cfg;
    logic [15:0] series_cfg;
    warm_thr    = WARM_RST;
    bad_limit   = LIMIT_RST;
    supply_r    = SUPPLY_RST;
    series_r    = SERIES_RST;
    first_kept  = ST_INVALID;
    second_kept = ST_INVALID;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned r = 0; r < DIR_ROWS; r++) begin
      s.first_probe_mv  = DIRECTED[r].first_mv;
      s.second_probe_mv = DIRECTED[r].second_mv;
      send_sample(s, DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        // Drop valid, let every result come home, then retune the block.
        in_valid <= 1'b0;
        wait_for_drain();
        case (phase)
          1: begin  // warm threshold above the limit: never warm; widest divider
            warm_cfg = 8'd200; limit_cfg = 8'd0; supply_cfg = 12'd4095; series_cfg = 16'd65535;
          end
          2: begin  // smallest supply and resistor: everything is invalid
            warm_cfg = 8'd0; limit_cfg = 8'd255; supply_cfg = 12'd1; series_cfg = 16'd1;
          end
          3: begin
            warm_cfg = 8'd200; limit_cfg = 8'd255; supply_cfg = 12'd4095; series_cfg = 16'd1;
          end
          4: begin
            warm_cfg = 8'd0; limit_cfg = 8'd200; supply_cfg = 12'd3300; series_cfg = 16'd1000;
          end
          default: begin
            warm_cfg   = $urandom_range(0, 200);
            limit_cfg  = $urandom_range(0, 255);
            supply_cfg = $urandom_range(200, 4095);
            series_cfg = $urandom_range(100, 20000);
          end
        endcase
        write_register(REG_WARM, 32'(warm_cfg));
        write_register(REG_LIMIT, 32'(limit_cfg));
        write_register(REG_SUPPLY, 32'(supply_cfg));
        write_register(REG_SERIES, 32'(series_cfg));
        // Stall the result side for a long stretch so the input backs up.
        if (phase == 1) hold_off_cycles = HOLD_OFF_LEN;
      end
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        s.first_probe_mv  = pick_sample_mv();
        s.second_probe_mv = pick_sample_mv();
        send_sample(s, 1'b0, UNTYPED);
      end
    end

    in_valid <= 1'b0;
    wait_for_drain();
    // Watch a little longer for stray beats.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: random stalls before each beat, with runs of no stalls and
  // one long hold-off on request.
  initial begin
    int unsigned stall;
    int unsigned beats;
    bit          no_stalls;
    out_data_t   want;
    beats = 0;
    no_stalls = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (beats % 50 == 0) no_stalls = ($urandom_range(0, 3) == 0);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = no_stalls ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
      if (expected_readings.size() == 0) begin
        $error("out_data: unexpected beat %h", out_data);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("first_status", want.first_status, out_data.first_status);
        check_field("first_event", want.first_event, out_data.first_event);
        check_field("first_led_toggle", want.first_led_toggle, out_data.first_led_toggle);
        check_field("first_degrees", want.first_degrees, out_data.first_degrees);
        check_field("second_status", want.second_status, out_data.second_status);
        check_field("second_event", want.second_event, out_data.second_event);
        check_field("second_led_toggle", want.second_led_toggle, out_data.second_led_toggle);
        check_field("second_degrees", want.second_degrees, out_data.second_degrees);
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #6000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
sv/rtdc_pkg.sv
sv/rtdc_lane.sv
sv/rtdc_merge.sv
sv/rtd_probe_temperature_classifier.sv
tb/testbench.sv
